/* src/dea_pkg.sv */
// shared types and constants for the disk extent allocator
// payload structs, status and opcode codes, controller/datapath interface
// no dependencies
package dea_pkg;

  // opcodes of an input item
  typedef enum logic [1:0] {
    OP_CLEAR     = 2'd0,
    OP_LOAD      = 2'd1,
    OP_CREATE_AT = 2'd2,
    OP_FIRST_FIT = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_BOOT    = 3'd2,
    ST_BEYOND  = 3'd3,
    ST_OVERLAP = 3'd4,
    ST_NOSPACE = 3'd5,
    ST_COMPACT = 3'd6
  } status_e;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_CYLINDER_COUNT = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_SECTORS_PER_CYL = 1'b1;

  // restoring divider length (dividend width)
  localparam int unsigned DivBits = 32;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] start_cylinder;
    logic [15:0] start_sector;
    logic [31:0] sector_count;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] placed_cylinder;
    logic [15:0] placed_sector;
    logic [3:0]  slot;
    logic [3:0]  extent_count;
  } rsp_t;

  // one table entry as stored in the ram
  typedef struct packed {
    logic [15:0] cyl;
    logic [15:0] sec;
    logic [31:0] len;
  } entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic    latch;
    logic    geo;
    logic    start;
    logic    clear;
    logic    mul;
    logic    add;
    logic    endc;
    logic    eval;
    logic    k_inc;
    logic    tail;
    logic    div_init;
    logic    div_step;
    logic    ins_init;
    logic    ins_rd;
    logic    ins_wr_move;
    logic    ins_wr_new;
    logic    set_res;
    status_e res_code;
    logic    out_load;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    op_e  op;
    logic full;
    logic boot;
    logic beyond;
    logic len_zero;
    logic k_end;
    logic ovl;
    logic fit;
    logic tail_fit;
    logic nospace;
    logic div_done;
    logic at_pos;
    logic out_busy;
  } dp_stat_t;

endpackage

/* src/dea_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
module dea_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic [AddrW-1:0]     raddr_i,
  output logic [Width-1:0]     rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* src/dea_datapath.sv */
// datapath of the disk extent allocator: geometry, extent table, scan, divider
// depends on dea_pkg and dea_ram
module dea_datapath #(
  parameter int unsigned MAX_EXTENTS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dea_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [15:0]                  cfg_wdata_i,
  input  dea_pkg::req_t                in_item_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output dea_pkg::rsp_t                out_item_o,
  input  dea_pkg::ctl_cmd_t            cmd_i,
  output dea_pkg::dp_stat_t            stat_o
);
  localparam int unsigned AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_EXTENTS);

  logic [15:0]       cc_q, spc_q;
  dea_pkg::req_t     req_q;
  logic [CW-1:0]     count_q, k_q, pos_q;
  logic              pos_set_q, ovl_q;
  logic [31:0]       tot_q, prod_q, prev_q, at_q, ent_len_q, quo_q;
  logic [32:0]       s_q, ds_q, fsum_q;
  logic [33:0]       e_q, de_q;
  logic [15:0]       ent_sec_q;
  logic [16:0]       rem_q;
  logic [5:0]        dcnt_q;
  dea_pkg::status_e  res_status_q;
  logic [15:0]       res_cyl_q, res_sec_q;
  logic [CW-1:0]     res_slot_q;
  dea_pkg::rsp_t     out_q;
  logic              out_valid_q;

  dea_pkg::op_e      op;
  dea_pkg::entry_t   rd_ent, new_ent;
  logic [AW-1:0]     raddr;
  logic              ram_we;
  logic [33:0]       e_now;
  logic [31:0]       dsc, dec, gap, tail;
  logic              fit, tail_fit;
  logic [33:0]       fsum_tail;
  logic [16:0]       div_r;
  logic              div_ge;
  logic [15:0]       mul_a;

  assign op = dea_pkg::op_e'(req_q.opcode);

  // extent table
  assign raddr  = cmd_i.ins_rd ? AW'(k_q - CW'(1)) : AW'(k_q);
  assign ram_we = cmd_i.ins_wr_move | cmd_i.ins_wr_new;
  assign new_ent.cyl = (op == dea_pkg::OP_FIRST_FIT) ? quo_q[15:0] : req_q.start_cylinder;
  assign new_ent.sec = (op == dea_pkg::OP_FIRST_FIT) ? rem_q[15:0] : req_q.start_sector;
  assign new_ent.len = req_q.sector_count;

  dea_ram #(
    .Width ($bits(dea_pkg::entry_t)),
    .Depth (MAX_EXTENTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(k_q)),
    .wdata_i (cmd_i.ins_wr_new ? new_ent : rd_ent),
    .raddr_i (raddr),
    .rdata_o (rd_ent)
  );

  // comparisons used by the checks and the scan
  assign e_now = {1'b0, s_q} + {2'b0, req_q.sector_count};
  assign dsc = (ds_q > {1'b0, tot_q}) ? tot_q : ds_q[31:0];
  assign dec = (de_q > {2'b0, tot_q}) ? tot_q : de_q[31:0];
  assign gap = (dsc > prev_q) ? (dsc - prev_q) : 32'd0;
  assign fit = gap >= req_q.sector_count;
  assign tail = (tot_q > prev_q) ? (tot_q - prev_q) : 32'd0;
  assign tail_fit = tail >= req_q.sector_count;
  assign fsum_tail = {1'b0, fsum_q} + {2'b0, tail};

  // one restoring divider step
  assign div_r  = {rem_q[15:0], quo_q[31]};
  assign div_ge = div_r >= {1'b0, spc_q};

  assign mul_a = cmd_i.geo ? req_q.start_cylinder : rd_ent.cyl;

  // status toward the controller
  always_comb begin
    stat_o.op       = op;
    stat_o.full     = count_q >= MaxCnt;
    stat_o.boot     = (req_q.start_cylinder == 16'd0) && (req_q.start_sector == 16'd0);
    stat_o.len_zero = req_q.sector_count == 32'd0;
    stat_o.beyond   = (req_q.sector_count == 32'd0) || (e_now > {2'b0, tot_q});
    stat_o.k_end    = k_q == count_q;
    stat_o.ovl      = ovl_q;
    stat_o.fit      = fit;
    stat_o.tail_fit = tail_fit;
    stat_o.nospace  = fsum_tail < {2'b0, req_q.sector_count};
    stat_o.div_done = dcnt_q == 6'd0;
    stat_o.at_pos   = k_q == pos_q;
    stat_o.out_busy = out_valid_q && out_stall_i;
  end

  // configuration registers, fill count, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q        <= 16'd1;
      spc_q       <= 16'd1;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          dea_pkg::CFG_CYLINDER_COUNT:  cc_q  <= cfg_wdata_i;
          dea_pkg::CFG_SECTORS_PER_CYL: spc_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.clear) begin
        count_q <= '0;
      end else if (cmd_i.ins_wr_new) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= in_item_i;
    end
    // geometry and start address
    if (cmd_i.geo) begin
      tot_q <= cc_q * spc_q;
    end
    if (cmd_i.geo || cmd_i.mul) begin
      prod_q <= mul_a * spc_q;
    end
    if (cmd_i.mul) begin
      ent_sec_q <= rd_ent.sec;
      ent_len_q <= rd_ent.len;
    end
    e_q <= e_now;
    if (cmd_i.start) begin
      s_q       <= {1'b0, prod_q} + {17'd0, req_q.start_sector};
      k_q       <= '0;
      pos_q     <= count_q;
      pos_set_q <= 1'b0;
      ovl_q     <= 1'b0;
      prev_q    <= 32'd1;
      fsum_q    <= '0;
    end
    // per entry bounds
    if (cmd_i.add) begin
      ds_q <= {1'b0, prod_q} + {17'd0, ent_sec_q};
    end
    if (cmd_i.endc) begin
      de_q <= {1'b0, ds_q} + {2'b0, ent_len_q};
    end
    // overlap and insertion point, or gap test
    if (cmd_i.eval) begin
      if (op == dea_pkg::OP_CREATE_AT) begin
        if ((s_q < de_q) && ({1'b0, ds_q} < e_q)) begin
          ovl_q <= 1'b1;
        end
        if ((ds_q > s_q) && !pos_set_q) begin
          pos_q     <= k_q;
          pos_set_q <= 1'b1;
        end
      end else if (fit) begin
        at_q  <= prev_q;
        pos_q <= k_q;
      end else begin
        fsum_q <= fsum_q + {1'b0, gap};
        if (dec > prev_q) begin
          prev_q <= dec;
        end
      end
    end
    if (cmd_i.k_inc) begin
      k_q <= k_q + CW'(1);
    end
    if (cmd_i.tail && tail_fit) begin
      at_q <= prev_q;
    end
    // linear address back to cylinder and sector
    if (cmd_i.div_init) begin
      quo_q  <= at_q;
      rem_q  <= '0;
      dcnt_q <= 6'(dea_pkg::DivBits);
    end else if (cmd_i.div_step) begin
      quo_q  <= {quo_q[30:0], div_ge};
      rem_q  <= div_ge ? (div_r - {1'b0, spc_q}) : div_r;
      dcnt_q <= dcnt_q - 6'd1;
    end
    // insertion shift runs from the end of the table down
    if (cmd_i.ins_init) begin
      k_q <= count_q;
    end else if (cmd_i.ins_wr_move) begin
      k_q <= k_q - CW'(1);
    end
    // result
    if (cmd_i.set_res) begin
      res_status_q <= cmd_i.res_code;
      res_cyl_q    <= '0;
      res_sec_q    <= '0;
      res_slot_q   <= '0;
    end else if (cmd_i.ins_wr_new) begin
      res_status_q <= dea_pkg::ST_OK;
      res_cyl_q    <= new_ent.cyl;
      res_sec_q    <= new_ent.sec;
      res_slot_q   <= k_q;
    end
    if (cmd_i.out_load) begin
      out_q.status          <= res_status_q;
      out_q.placed_cylinder <= res_cyl_q;
      out_q.placed_sector   <= res_sec_q;
      out_q.slot            <= 4'(res_slot_q);
      out_q.extent_count    <= 4'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
endmodule

/* src/dea_ctrl.sv */
// controller state machine of the disk extent allocator
// depends on dea_pkg
module dea_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dea_pkg::dp_stat_t  stat_i,
  output dea_pkg::ctl_cmd_t  cmd_o
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GEO   = 4'd1;
  localparam logic [3:0] S_START = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_ADD   = 4'd6;
  localparam logic [3:0] S_ENDA  = 4'd7;
  localparam logic [3:0] S_EVAL  = 4'd8;
  localparam logic [3:0] S_TAIL  = 4'd9;
  localparam logic [3:0] S_DIVS  = 4'd10;
  localparam logic [3:0] S_DIV   = 4'd11;
  localparam logic [3:0] S_INS   = 4'd12;
  localparam logic [3:0] S_MOVE  = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_code = dea_pkg::ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_GEO;
        end
      end
      S_GEO: begin
        cmd_o.geo = 1'b1;
        state_d   = S_START;
      end
      S_START: begin
        cmd_o.start = 1'b1;
        state_d     = S_CHECK;
      end
      // decode the item and run the up-front checks
      S_CHECK: begin
        state_d       = S_DONE;
        cmd_o.set_res = 1'b1;
        unique case (stat_i.op)
          dea_pkg::OP_CLEAR: begin
            cmd_o.clear = 1'b1;
          end
          dea_pkg::OP_LOAD: begin
            if (stat_i.full) begin
              cmd_o.res_code = dea_pkg::ST_FULL;
            end else begin
              cmd_o.set_res  = 1'b0;
              cmd_o.ins_init = 1'b1;
              state_d        = S_INS;
            end
          end
          dea_pkg::OP_CREATE_AT: begin
            if (stat_i.full) begin
              cmd_o.res_code = dea_pkg::ST_FULL;
            end else if (stat_i.boot) begin
              cmd_o.res_code = dea_pkg::ST_BOOT;
            end else if (stat_i.beyond) begin
              cmd_o.res_code = dea_pkg::ST_BEYOND;
            end else begin
              cmd_o.set_res = 1'b0;
              state_d       = S_RD;
            end
          end
          dea_pkg::OP_FIRST_FIT: begin
            if (stat_i.full) begin
              cmd_o.res_code = dea_pkg::ST_FULL;
            end else if (stat_i.len_zero) begin
              cmd_o.res_code = dea_pkg::ST_BEYOND;
            end else begin
              cmd_o.set_res = 1'b0;
              state_d       = S_RD;
            end
          end
        endcase
      end
      // table scan, one entry per pass
      S_RD: begin
        if (!stat_i.k_end) begin
          state_d = S_MUL;
        end else if (stat_i.op == dea_pkg::OP_CREATE_AT) begin
          if (stat_i.ovl) begin
            cmd_o.set_res  = 1'b1;
            cmd_o.res_code = dea_pkg::ST_OVERLAP;
            state_d        = S_DONE;
          end else begin
            cmd_o.ins_init = 1'b1;
            state_d        = S_INS;
          end
        end else begin
          state_d = S_TAIL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ADD;
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = S_ENDA;
      end
      S_ENDA: begin
        cmd_o.endc = 1'b1;
        state_d    = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if ((stat_i.op == dea_pkg::OP_FIRST_FIT) && stat_i.fit) begin
          state_d = S_DIVS;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = S_RD;
        end
      end
      // free space behind the last extent
      S_TAIL: begin
        cmd_o.tail = 1'b1;
        if (stat_i.tail_fit) begin
          state_d = S_DIVS;
        end else begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = stat_i.nospace ? dea_pkg::ST_NOSPACE : dea_pkg::ST_COMPACT;
          state_d        = S_DONE;
        end
      end
      S_DIVS: begin
        cmd_o.div_init = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.ins_init = 1'b1;
          state_d        = S_INS;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      // move entries up one slot, then write the new one
      S_INS: begin
        if (stat_i.at_pos) begin
          cmd_o.ins_wr_new = 1'b1;
          state_d          = S_DONE;
        end else begin
          cmd_o.ins_rd = 1'b1;
          state_d      = S_MOVE;
        end
      end
      S_MOVE: begin
        cmd_o.ins_wr_move = 1'b1;
        state_d           = S_INS;
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end
endmodule

/* src/disk_extent_allocator.sv */
// per item: clear and failed checks go straight to the result, a load inserts at the end; a scan
// reads each entry, first fit then checks the tail and divides, inserts move entries up one by one
// one item at a time; the next is taken after the previous result is registered, back in idle
// reset: asynchronous active low; table empty, geometry 1 x 1; table ram is not cleared
// top level of the disk extent allocator: controller plus datapath
// depends on dea_pkg, dea_ctrl, dea_datapath
module disk_extent_allocator #(
  parameter int unsigned MAX_EXTENTS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dea_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [15:0]                  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  dea_pkg::req_t                in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output dea_pkg::rsp_t                out_item_o
);
  dea_pkg::ctl_cmd_t cmd;
  dea_pkg::dp_stat_t stat;

  dea_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dea_datapath #(
    .MAX_EXTENTS (MAX_EXTENTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );
endmodule

/* src/dea_checker.sv */
// port-level checks for the disk extent allocator, bound to the top level
// depends on dea_pkg
module dea_checker #(
  parameter int unsigned MAX_EXTENTS = 8
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input dea_pkg::rsp_t out_item_o
);
  // a result waits while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item accepted while busy");

  // failures carry no placement
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != dea_pkg::ST_OK) |->
      (out_item_o.slot == 4'd0) && (out_item_o.placed_cylinder == 16'd0)
      && (out_item_o.placed_sector == 16'd0))
    else $error("failed item reports a placement");

  // the fill count stays within the table and the status is a defined code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_item_o.extent_count) <= MAX_EXTENTS)
      && (out_item_o.status != 3'd7))
    else $error("bad extent count or status");
endmodule

bind disk_extent_allocator dea_checker #(
  .MAX_EXTENTS (MAX_EXTENTS)
) u_dea_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

/* dv/dea_checker.sv */
// checker for the disk extent allocator: watches config writes and both item channels
// keeps its own copy of the extent list and geometry, predicts each result and compares
// depends on dea_pkg
module dea_scoreboard (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dea_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [15:0]                 cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  dea_pkg::req_t               in_item_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  dea_pkg::rsp_t               out_item_i,
  output int                          pending_o,
  output int                          errors_o,
  output int                          checked_o,
  output int                          placed_ok_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxExtents = 8;

  // shadow extent list and geometry
  logic [15:0] ext_cyl [MaxExtents];
  logic [15:0] ext_sec [MaxExtents];
  logic [31:0] ext_len [MaxExtents];
  int unsigned ext_used;
  logic [15:0] geo_cyls;
  logic [15:0] geo_spc;

  dea_pkg::rsp_t expected_rsp_q[$];

  assign pending_o = expected_rsp_q.size();

  // put a new extent at pos and move the ones behind it up
  function automatic void insert_extent(int unsigned pos, logic [15:0] c, logic [15:0] s,
                                        logic [31:0] l);
    for (int unsigned j = ext_used; j > pos; j--) begin
      ext_cyl[j] = ext_cyl[j-1];
      ext_sec[j] = ext_sec[j-1];
      ext_len[j] = ext_len[j-1];
    end
    ext_cyl[pos] = c;
    ext_sec[pos] = s;
    ext_len[pos] = l;
    ext_used++;
  endfunction

  // work out the answer to one request and update the shadow list
  function automatic dea_pkg::rsp_t place_extent(dea_pkg::req_t r);
    dea_pkg::rsp_t res;
    logic [63:0]   disk_size, s, e, ds, de, gap, prev, free_sum, at, tail;
    int unsigned   pos;
    logic          found;
    disk_size = 64'(geo_cyls) * 64'(geo_spc);
    res = '0;
    res.status = dea_pkg::ST_OK;
    if (dea_pkg::op_e'(r.opcode) == dea_pkg::OP_CLEAR) begin
      ext_used = 0;
    end else if (ext_used >= MaxExtents) begin
      res.status = dea_pkg::ST_FULL;
    end else if (dea_pkg::op_e'(r.opcode) == dea_pkg::OP_LOAD) begin
      res.slot = 4'(ext_used);
      insert_extent(ext_used, r.start_cylinder, r.start_sector, r.sector_count);
      res.placed_cylinder = r.start_cylinder;
      res.placed_sector = r.start_sector;
    end else if (dea_pkg::op_e'(r.opcode) == dea_pkg::OP_CREATE_AT) begin
      s = 64'(r.start_cylinder) * 64'(geo_spc) + 64'(r.start_sector);
      e = s + 64'(r.sector_count);
      if (r.start_cylinder == 0 && r.start_sector == 0) begin
        res.status = dea_pkg::ST_BOOT;
      end else if (r.sector_count == 0 || e > disk_size) begin
        res.status = dea_pkg::ST_BEYOND;
      end else begin
        pos = ext_used;
        for (int unsigned k = 0; k < ext_used; k++) begin
          ds = 64'(ext_cyl[k]) * 64'(geo_spc) + 64'(ext_sec[k]);
          de = ds + 64'(ext_len[k]);
          if (s < de && ds < e) res.status = dea_pkg::ST_OVERLAP;
          if (ds > s && pos == ext_used) pos = k;
        end
        if (res.status == dea_pkg::ST_OK) begin
          res.slot = 4'(pos);
          insert_extent(pos, r.start_cylinder, r.start_sector, r.sector_count);
          res.placed_cylinder = r.start_cylinder;
          res.placed_sector = r.start_sector;
        end
      end
    end else if (r.sector_count == 0) begin
      res.status = dea_pkg::ST_BEYOND;
    end else begin
      // first fit: scan gaps from block 1, clamped to the disk
      prev = 1;
      free_sum = 0;
      at = 0;
      found = 1'b0;
      pos = 0;
      for (int unsigned k = 0; k < ext_used && !found; k++) begin
        ds = 64'(ext_cyl[k]) * 64'(geo_spc) + 64'(ext_sec[k]);
        de = ds + 64'(ext_len[k]);
        if (ds > disk_size) ds = disk_size;
        if (de > disk_size) de = disk_size;
        gap = (ds > prev) ? ds - prev : 64'd0;
        if (gap >= 64'(r.sector_count)) begin
          found = 1'b1;
          at = prev;
          pos = k;
        end else begin
          free_sum += gap;
          if (de > prev) prev = de;
        end
      end
      if (!found) begin
        tail = (disk_size > prev) ? disk_size - prev : 64'd0;
        if (tail >= 64'(r.sector_count)) begin
          found = 1'b1;
          at = prev;
          pos = ext_used;
        end else begin
          free_sum += tail;
        end
      end
      if (found && geo_spc != 0) begin
        res.placed_cylinder = 16'(at / 64'(geo_spc));
        res.placed_sector = 16'(at % 64'(geo_spc));
        res.slot = 4'(pos);
        insert_extent(pos, res.placed_cylinder, res.placed_sector, r.sector_count);
      end else begin
        res.status = (free_sum < 64'(r.sector_count)) ? dea_pkg::ST_NOSPACE
                                                      : dea_pkg::ST_COMPACT;
      end
    end
    res.extent_count = 4'(ext_used);
    return res;
  endfunction

  // compare results, then track config and predict new items
  always @(posedge clk_i or negedge rst_ni) begin
    dea_pkg::rsp_t want;
    if (!rst_ni) begin
      ext_used = 0;
      geo_cyls = 16'd1;
      geo_spc = 16'd1;
      errors_o <= 0;
      checked_o <= 0;
      placed_ok_o <= 0;
      expected_rsp_q.delete();
      for (int i = 0; i < MaxExtents; i++) begin
        ext_cyl[i] = '0;
        ext_sec[i] = '0;
        ext_len[i] = '0;
      end
    end else begin
      if (out_valid_i && !out_stall_i) begin
        checked_o <= checked_o + 1;
        if (expected_rsp_q.size() == 0) begin
          $error("result with no request waiting: %p", out_item_i);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_rsp_q.pop_front();
          if (want.status == dea_pkg::ST_OK) placed_ok_o <= placed_ok_o + 1;
          if (out_item_i !== want) errors_o <= errors_o + 1;
          if (out_item_i.status !== want.status)
            $error("status: expected %0d, got %0d", want.status, out_item_i.status);
          if (out_item_i.placed_cylinder !== want.placed_cylinder)
            $error("placed_cylinder: expected %0d, got %0d", want.placed_cylinder,
                   out_item_i.placed_cylinder);
          if (out_item_i.placed_sector !== want.placed_sector)
            $error("placed_sector: expected %0d, got %0d", want.placed_sector,
                   out_item_i.placed_sector);
          if (out_item_i.slot !== want.slot)
            $error("slot: expected %0d, got %0d", want.slot, out_item_i.slot);
          if (out_item_i.extent_count !== want.extent_count)
            $error("extent_count: expected %0d, got %0d", want.extent_count,
                   out_item_i.extent_count);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == dea_pkg::CFG_CYLINDER_COUNT) geo_cyls = cfg_wdata_i;
        else if (cfg_idx_i == dea_pkg::CFG_SECTORS_PER_CYL) geo_spc = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) expected_rsp_q.push_back(place_extent(in_item_i));
    end
  end

endmodule

/* dv/tb_disk_extent_allocator.sv */
// testbench top for the disk extent allocator: clock, reset, stimulus and verdict
// directed requests, then random requests over several geometries, checked by dea_scoreboard
// depends on dea_pkg, dea_scoreboard, disk_extent_allocator
module tb_disk_extent_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 5000;
  localparam int HoldCycles = 300;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [dea_pkg::CfgIdxW-1:0] cfg_idx = '0;
  logic [15:0]                 cfg_wdata = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  dea_pkg::req_t               in_item = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  dea_pkg::rsp_t               out_item;
  int                          pending, errors, checked, placed_ok;
  int                          items_sent = 0;
  int                          burst_left = 0;
  logic                        hold_req = 1'b0;
  logic [15:0]                 cur_cyls = 16'd1;
  logic [15:0]                 cur_spc = 16'd1;

  always #5 clk = ~clk;

  disk_extent_allocator dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item)
  );

  dea_scoreboard u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_item_i(in_item),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_item_i(out_item),
    .pending_o(pending), .errors_o(errors), .checked_o(checked), .placed_ok_o(placed_ok)
  );

  // receiver stall pattern with a randomly chosen mode, plus one long hold-off
  always @(posedge clk) begin
    static int cyc = 0;
    static int mode = 0;
    static int hold_left = 0;
    static bit hold_taken = 0;
    cyc++;
    if (cyc % 64 == 0) mode = $urandom_range(3, 0);
    if (hold_req && !hold_taken) begin
      hold_taken = 1;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(1, 0) == 0);
        2: out_stall <= ($urandom_range(9, 0) == 0);
        default: out_stall <= cyc[1];
      endcase
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    static int idle = 0;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
    else idle++;
    if (idle >= IdleLimit) begin
      $display("timeout: no item moved for %0d cycles", IdleLimit);
      $display("FAIL");
      $finish;
    end
  end

  // offer one item until taken, then maybe open a gap between bursts
  task automatic send_req(dea_pkg::req_t r);
    in_item <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(20, 0);
      in_valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
  endtask

  task automatic send_op(dea_pkg::op_e op, int unsigned c, int unsigned s, int unsigned l);
    dea_pkg::req_t r;
    r.opcode = op;
    r.start_cylinder = 16'(c);
    r.start_sector = 16'(s);
    r.sector_count = l;
    send_req(r);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_geometry(logic [15:0] cyls, logic [15:0] spc);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= dea_pkg::CFG_CYLINDER_COUNT;
    cfg_wdata <= cyls;
    @(posedge clk);
    cfg_idx <= dea_pkg::CFG_SECTORS_PER_CYL;
    cfg_wdata <= spc;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_cyls = cyls;
    cur_spc = spc;
  endtask

  // random request, mostly sized to the current disk, sometimes raw noise
  function automatic dea_pkg::req_t rand_req();
    dea_pkg::req_t r;
    logic [63:0]   disk_size, lim;
    int unsigned   pick;
    disk_size = 64'(cur_cyls) * 64'(cur_spc);
    pick = $urandom_range(99, 0);
    if (pick < 7) r.opcode = dea_pkg::OP_CLEAR;
    else if (pick < 20) r.opcode = dea_pkg::OP_LOAD;
    else if (pick < 55) r.opcode = dea_pkg::OP_CREATE_AT;
    else r.opcode = dea_pkg::OP_FIRST_FIT;
    if ($urandom_range(9, 0) == 0) begin
      r.start_cylinder = 16'($urandom);
      r.start_sector = 16'($urandom);
      r.sector_count = $urandom;
    end else begin
      r.start_cylinder = 16'($urandom_range(int'(cur_cyls), 0));
      r.start_sector = 16'($urandom_range(int'(cur_spc), 0));
      lim = disk_size >> $urandom_range(6, 1);
      if (lim == 0) lim = 2;
      if (lim > 64'hFFFF_FFFF) lim = 64'hFFFF_FFFF;
      r.sector_count = $urandom_range(32'(lim), 0);
    end
    return r;
  endfunction

  initial begin
    logic [15:0] geo_list [6][2];
    geo_list = '{'{16'd1, 16'd1}, '{16'd0, 16'd5}, '{16'd100, 16'd63},
                 '{16'd65535, 16'd65535}, '{16'd3, 16'd17}, '{16'd1000, 16'd255}};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: small 10 x 10 disk
    set_geometry(16'd10, 16'd10);
    send_op(dea_pkg::OP_CLEAR, 0, 0, 0);
    send_op(dea_pkg::OP_CREATE_AT, 0, 0, 5);
    send_op(dea_pkg::OP_CREATE_AT, 1, 0, 0);
    send_op(dea_pkg::OP_CREATE_AT, 9, 5, 6);
    send_op(dea_pkg::OP_CREATE_AT, 5, 0, 10);
    send_op(dea_pkg::OP_CREATE_AT, 4, 5, 10);
    send_op(dea_pkg::OP_FIRST_FIT, 0, 0, 0);
    send_op(dea_pkg::OP_FIRST_FIT, 0, 0, 60);
    send_op(dea_pkg::OP_FIRST_FIT, 0, 0, 95);
    send_op(dea_pkg::OP_FIRST_FIT, 0, 0, 3);
    send_op(dea_pkg::OP_CREATE_AT, 0, 55, 2);
    send_op(dea_pkg::OP_LOAD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_op(dea_pkg::OP_FIRST_FIT, 0, 0, 1);
    send_op(dea_pkg::OP_LOAD, 2, 3, 4);
    send_op(dea_pkg::OP_LOAD, 0, 0, 0);
    send_op(dea_pkg::OP_LOAD, 7, 7, 1);
    send_op(dea_pkg::OP_CREATE_AT, 8, 0, 1);
    send_op(dea_pkg::OP_FIRST_FIT, 0, 0, 1);
    send_op(dea_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    // big disk: address just inside and just past the end
    set_geometry(16'hFFFF, 16'hFFFF);
    send_op(dea_pkg::OP_CREATE_AT, 16'hFFFE, 16'hFFFE, 1);
    send_op(dea_pkg::OP_CREATE_AT, 16'hFFFE, 16'hFFFF, 1);
    send_op(dea_pkg::OP_FIRST_FIT, 0, 0, 32'hFFFF_FFFF);
    send_op(dea_pkg::OP_FIRST_FIT, 0, 0, 32'h8000_0000);

    // random phases over several geometries
    foreach (geo_list[g]) begin
      set_geometry(geo_list[g][0], geo_list[g][1]);
      if (g == 2) hold_req <= 1'b1;
      repeat (312) send_req(rand_req());
    end

    drain();
    repeat (100) @(posedge clk);
    $display("sent %0d requests over 8 geometries, %0d results checked, %0d placed ok",
             items_sent, checked, placed_ok);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
